### sv/cpu_alu_with_flags_defines.svh
// assertion macros for the cpu_alu_with_flags block
// no dependencies; included by files that carry concurrent checks
`ifndef CPU_ALU_WITH_FLAGS_DEFINES_SVH
`define CPU_ALU_WITH_FLAGS_DEFINES_SVH
`ifndef SYNTH
`define CAWF_ASSERT_IMPLY(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("cawf check failed");
`define CAWF_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("cawf check failed");
`else
`define CAWF_ASSERT_IMPLY(lbl, ante, cons)
`define CAWF_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### sv/cawf_pkg.sv
// shared types, widths and operation codes for the cpu alu with flags
// no dependencies
package cawf_pkg;

   localparam int OP_W   = 5;
   localparam int BYTE_W = 8;
   localparam int WORD_W = 16;
   localparam int BIT_W  = 3;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 24;

   localparam logic [OP_W-1:0] OP_ADD    = 5'd0;
   localparam logic [OP_W-1:0] OP_ADC    = 5'd1;
   localparam logic [OP_W-1:0] OP_SUB    = 5'd2;
   localparam logic [OP_W-1:0] OP_SBC    = 5'd3;
   localparam logic [OP_W-1:0] OP_AND    = 5'd4;
   localparam logic [OP_W-1:0] OP_XOR    = 5'd5;
   localparam logic [OP_W-1:0] OP_OR     = 5'd6;
   localparam logic [OP_W-1:0] OP_CP     = 5'd7;
   localparam logic [OP_W-1:0] OP_INC    = 5'd8;
   localparam logic [OP_W-1:0] OP_DEC    = 5'd9;
   localparam logic [OP_W-1:0] OP_RLC    = 5'd10;
   localparam logic [OP_W-1:0] OP_RRC    = 5'd11;
   localparam logic [OP_W-1:0] OP_RL     = 5'd12;
   localparam logic [OP_W-1:0] OP_RR     = 5'd13;
   localparam logic [OP_W-1:0] OP_SLA    = 5'd14;
   localparam logic [OP_W-1:0] OP_SRA    = 5'd15;
   localparam logic [OP_W-1:0] OP_SWAP   = 5'd16;
   localparam logic [OP_W-1:0] OP_SRL    = 5'd17;
   localparam logic [OP_W-1:0] OP_BIT    = 5'd18;
   localparam logic [OP_W-1:0] OP_ADD16  = 5'd19;
   localparam logic [OP_W-1:0] OP_ADDSP  = 5'd20;

   typedef struct packed {
      logic             zero_in;
      logic             carry_in;
      logic [BIT_W-1:0] bit_index;
      logic [WORD_W-1:0] operand;
      logic [WORD_W-1:0] reg_value;
      logic [BYTE_W-1:0] acc;
      logic [OP_W-1:0]  operation;
   } cawf_req_type;

   typedef struct packed {
      logic carry;
      logic half;
      logic negative;
      logic zero;
   } cawf_flags_type;

   typedef struct packed {
      cawf_flags_type    flags;
      logic [WORD_W-1:0] result;
   } cawf_rsp_type;

endpackage

### sv/cpu_alu_with_flags.sv
// top level of the 8-bit cpu alu with zero, negative, half-carry and carry flags
// depends on cawf_pkg, cawf_alu, cawf_out_reg and cpu_alu_with_flags_defines.svh

// One result leaves for every request, after it passes the request register and
// then the result register. A new request is taken every cycle while the result
// side does not stall; the combinational alu datapath sits between those two
// registers. The request register keeps accepting while a finished result waits
// on the result side, and the block stalls only when both registers are full.
`include "cpu_alu_with_flags_defines.svh"
module cpu_alu_with_flags (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // acc, reg_value, operand, bit_index, carry_in, zero_in, zero pad
   input  logic [47:0] req_tdata,
   // operation
   input  logic [4:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // result, zero_flag, negative_flag, half_flag, carry_flag, zero pad
   output logic [23:0] rsp_tdata
);
   import cawf_pkg::*;

   logic         s1_valid_ff;
   logic         s1_valid_in;
   cawf_req_type s1_req_ff;
   cawf_req_type req_in;
   cawf_rsp_type alu_rsp;
   cawf_rsp_type out_rsp;
   logic         out_ready;
   logic         s1_advance;
   logic         req_xfer;

   assign req_in = {req_tdata[44:0], req_tuser};

   assign s1_advance  = s1_valid_ff && out_ready;
   assign req_tready  = !s1_valid_ff || out_ready;
   assign req_xfer    = req_tvalid && req_tready;
   assign s1_valid_in = req_xfer || (s1_valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_req_ff <= req_in;
      end
   end

   cawf_alu u_alu (
      .req (s1_req_ff),
      .rsp (alu_rsp)
   );

   cawf_out_reg u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid_ff),
      .in_ready  (out_ready),
      .in_data   (alu_rsp),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_rsp)
   );

   assign rsp_tdata = {{(RSP_DATA_W-WORD_W-4){1'b0}}, out_rsp};

   `CAWF_ASSERT_NEXT(a_req_loads_stage, req_xfer, s1_valid_ff)
   `CAWF_ASSERT_IMPLY(a_full_blocks_req, s1_valid_ff && rsp_tvalid && !rsp_tready, !req_tready)
   `CAWF_ASSERT_NEXT(a_cp_keeps_acc, s1_advance && (s1_req_ff.operation == OP_CP), rsp_tvalid && (rsp_tdata[15:0] == {8'd0, $past(s1_req_ff.acc)}))

endmodule

### sv/cawf_alu.sv
// combinational alu datapath: one operation to result and four flags
// depends on cawf_pkg
module cawf_alu (
   input  cawf_pkg::cawf_req_type req,
   output cawf_pkg::cawf_rsp_type rsp
);
   import cawf_pkg::*;

   logic [BYTE_W-1:0] a;
   logic [BYTE_W-1:0] n8;
   logic [BYTE_W-1:0] r8;
   logic              t;
   logic [BYTE_W:0]   sum9;
   logic [4:0]        sum_nib;
   logic [BYTE_W:0]   diff9;
   logic [4:0]        diff_nib;
   logic [WORD_W:0]   sum17;
   logic [12:0]       sum13;
   logic [BYTE_W:0]   sp_byte;
   logic [4:0]        sp_nib;
   logic [WORD_W-1:0] sp_sum;
   logic [BYTE_W-1:0] res8;

   assign a  = req.acc;
   assign n8 = req.operand[BYTE_W-1:0];
   assign r8 = req.reg_value[BYTE_W-1:0];
   assign t  = ((req.operation == OP_ADC) || (req.operation == OP_SBC)) ? req.carry_in : 1'b0;

   assign sum9     = {1'b0, a} + {1'b0, n8} + {{BYTE_W{1'b0}}, t};
   assign sum_nib  = {1'b0, a[3:0]} + {1'b0, n8[3:0]} + {4'd0, t};
   assign diff9    = {1'b0, a} - {1'b0, n8} - {{BYTE_W{1'b0}}, t};
   assign diff_nib = {1'b0, a[3:0]} - {1'b0, n8[3:0]} - {4'd0, t};
   assign sum17    = {1'b0, req.reg_value} + {1'b0, req.operand};
   assign sum13    = {1'b0, req.reg_value[11:0]} + {1'b0, req.operand[11:0]};
   assign sp_byte  = {1'b0, r8} + {1'b0, n8};
   assign sp_nib   = {1'b0, req.reg_value[3:0]} + {1'b0, n8[3:0]};
   assign sp_sum   = req.reg_value + {{(WORD_W-BYTE_W){n8[BYTE_W-1]}}, n8};

   always_comb begin
      rsp.result         = '0;
      rsp.flags.zero     = req.zero_in;
      rsp.flags.negative = 1'b0;
      rsp.flags.half     = 1'b0;
      rsp.flags.carry    = req.carry_in;
      res8               = '0;
      unique case (req.operation)
         OP_ADD, OP_ADC: begin
            res8            = sum9[BYTE_W-1:0];
            rsp.flags.half  = sum_nib[4];
            rsp.flags.carry = sum9[BYTE_W];
            rsp.flags.zero  = (res8 == '0);
            rsp.result      = {8'd0, res8};
         end
         OP_SUB, OP_SBC, OP_CP: begin
            res8               = diff9[BYTE_W-1:0];
            rsp.flags.half     = diff_nib[4];
            rsp.flags.carry    = diff9[BYTE_W];
            rsp.flags.zero     = (res8 == '0);
            rsp.flags.negative = 1'b1;
            rsp.result         = {8'd0, (req.operation == OP_CP) ? a : res8};
         end
         OP_AND: begin
            res8            = a & n8;
            rsp.flags.half  = 1'b1;
            rsp.flags.carry = 1'b0;
            rsp.flags.zero  = (res8 == '0);
            rsp.result      = {8'd0, res8};
         end
         OP_XOR, OP_OR: begin
            res8            = (req.operation == OP_XOR) ? (a ^ n8) : (a | n8);
            rsp.flags.carry = 1'b0;
            rsp.flags.zero  = (res8 == '0);
            rsp.result      = {8'd0, res8};
         end
         OP_INC: begin
            res8           = r8 + 8'd1;
            rsp.flags.half = (r8[3:0] == 4'hf);
            rsp.flags.zero = (res8 == '0);
            rsp.result     = {8'd0, res8};
         end
         OP_DEC: begin
            res8               = r8 - 8'd1;
            rsp.flags.half     = (r8[3:0] == 4'h0);
            rsp.flags.negative = 1'b1;
            rsp.flags.zero     = (res8 == '0);
            rsp.result         = {8'd0, res8};
         end
         OP_RLC, OP_RL, OP_SLA: begin
            rsp.flags.carry = r8[7];
            case (req.operation)
               OP_RLC:  res8 = {r8[6:0], r8[7]};
               OP_RL:   res8 = {r8[6:0], req.carry_in};
               default: res8 = {r8[6:0], 1'b0};
            endcase
            rsp.flags.zero = (res8 == '0);
            rsp.result     = {8'd0, res8};
         end
         OP_RRC, OP_RR, OP_SRA, OP_SRL: begin
            rsp.flags.carry = r8[0];
            case (req.operation)
               OP_RRC:  res8 = {r8[0], r8[7:1]};
               OP_RR:   res8 = {req.carry_in, r8[7:1]};
               OP_SRA:  res8 = {r8[7], r8[7:1]};
               default: res8 = {1'b0, r8[7:1]};
            endcase
            rsp.flags.zero = (res8 == '0);
            rsp.result     = {8'd0, res8};
         end
         OP_SWAP: begin
            res8            = {r8[3:0], r8[7:4]};
            rsp.flags.carry = 1'b0;
            rsp.flags.zero  = (res8 == '0);
            rsp.result      = {8'd0, res8};
         end
         OP_BIT: begin
            rsp.result     = {8'd0, r8};
            rsp.flags.zero = ~r8[req.bit_index];
            rsp.flags.half = 1'b1;
         end
         OP_ADD16: begin
            rsp.result      = sum17[WORD_W-1:0];
            rsp.flags.half  = sum13[12];
            rsp.flags.carry = sum17[WORD_W];
         end
         OP_ADDSP: begin
            rsp.result      = sp_sum;
            rsp.flags.half  = sp_nib[4];
            rsp.flags.carry = sp_byte[BYTE_W];
            rsp.flags.zero  = 1'b0;
         end
         default: begin
            rsp.result = '0;
         end
      endcase
   end

endmodule

### sv/cawf_out_reg.sv
// result register on the master side, holds a result while the result side stalls
// depends on cawf_pkg
module cawf_out_reg (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  cawf_pkg::cawf_rsp_type in_data,
   output logic                   out_valid,
   input  logic                   out_ready,
   output cawf_pkg::cawf_rsp_type out_data
);
   import cawf_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   cawf_rsp_type data_ff;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_valid || (valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= in_data;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

### test/alu_flag_checker.sv
// checker for the cpu alu with flags: watches both stream channels, predicts each result
// from the request transfer and compares every field in order of arrival
// depends on cawf_pkg for the operation codes
module alu_flag_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [47:0] req_tdata,
   input  logic [4:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,
   output int          error_count,
   output int          pending_count
);
   import cawf_pkg::*;

   // same layout as the low bits of rsp_tdata
   typedef struct packed {
      logic        carry;
      logic        half;
      logic        negative;
      logic        zero;
      logic [15:0] result;
   } alu_result_type;

   alu_result_type alu_result_q[$];

   function automatic alu_result_type compute_alu(input logic [4:0] op, input logic [47:0] d);
      logic [7:0]  a, n8, r8, res8;
      logic [15:0] r16, w;
      logic [2:0]  bidx;
      logic        cin, zin, t, byte_op;
      logic [8:0]  sum9, rhs9;
      logic [4:0]  nib, rhs5;
      logic [12:0] sum13;
      logic [16:0] sum17;
      alu_result_type y;
      a    = d[7:0];
      r16  = d[23:8];
      w    = d[39:24];
      bidx = d[42:40];
      cin  = d[43];
      zin  = d[44];
      n8   = w[7:0];
      r8   = r16[7:0];
      res8 = 8'd0;
      byte_op = 1'b1;
      y.result   = 16'd0;
      y.zero     = zin;
      y.negative = 1'b0;
      y.half     = 1'b0;
      y.carry    = cin;
      case (op)
         OP_ADD, OP_ADC: begin
            t      = (op == OP_ADC) & cin;
            sum9   = {1'b0, a} + {1'b0, n8} + {8'd0, t};
            nib    = {1'b0, a[3:0]} + {1'b0, n8[3:0]} + {4'd0, t};
            res8   = sum9[7:0];
            y.half = nib[4];
            y.carry = sum9[8];
         end
         OP_SUB, OP_SBC, OP_CP: begin
            t       = (op == OP_SBC) & cin;
            rhs5    = {1'b0, n8[3:0]} + {4'd0, t};
            rhs9    = {1'b0, n8} + {8'd0, t};
            y.half  = {1'b0, a[3:0]} < rhs5;
            y.carry = {1'b0, a} < rhs9;
            res8    = a - n8 - {7'd0, t};
            y.negative = 1'b1;
         end
         OP_AND: begin
            res8 = a & n8;
            y.half = 1'b1;
            y.carry = 1'b0;
         end
         OP_XOR: begin
            res8 = a ^ n8;
            y.carry = 1'b0;
         end
         OP_OR: begin
            res8 = a | n8;
            y.carry = 1'b0;
         end
         OP_INC: begin
            res8 = r8 + 8'd1;
            y.half = (r8[3:0] == 4'hf);
         end
         OP_DEC: begin
            res8 = r8 - 8'd1;
            y.half = (r8[3:0] == 4'h0);
            y.negative = 1'b1;
         end
         OP_RLC: begin
            res8 = {r8[6:0], r8[7]};
            y.carry = r8[7];
         end
         OP_RRC: begin
            res8 = {r8[0], r8[7:1]};
            y.carry = r8[0];
         end
         OP_RL: begin
            res8 = {r8[6:0], cin};
            y.carry = r8[7];
         end
         OP_RR: begin
            res8 = {cin, r8[7:1]};
            y.carry = r8[0];
         end
         OP_SLA: begin
            res8 = {r8[6:0], 1'b0};
            y.carry = r8[7];
         end
         OP_SRA: begin
            res8 = {r8[7], r8[7:1]};
            y.carry = r8[0];
         end
         OP_SWAP: begin
            res8 = {r8[3:0], r8[7:4]};
            y.carry = 1'b0;
         end
         OP_SRL: begin
            res8 = {1'b0, r8[7:1]};
            y.carry = r8[0];
         end
         OP_BIT: begin
            byte_op  = 1'b0;
            y.result = {8'd0, r8};
            y.zero   = ~r8[bidx];
            y.half   = 1'b1;
         end
         OP_ADD16: begin
            byte_op  = 1'b0;
            sum13    = {1'b0, r16[11:0]} + {1'b0, w[11:0]};
            sum17    = {1'b0, r16} + {1'b0, w};
            y.half   = sum13[12];
            y.carry  = sum17[16];
            y.result = sum17[15:0];
         end
         OP_ADDSP: begin
            byte_op  = 1'b0;
            nib      = {1'b0, r16[3:0]} + {1'b0, n8[3:0]};
            sum9     = {1'b0, r16[7:0]} + {1'b0, n8};
            y.half   = nib[4];
            y.carry  = sum9[8];
            y.zero   = 1'b0;
            y.result = r16 + {{8{n8[7]}}, n8};
         end
         default: begin
            byte_op = 1'b0;
         end
      endcase
      if (byte_op) begin
         y.zero   = (res8 == 8'd0);
         y.result = (op == OP_CP) ? {8'd0, a} : {8'd0, res8};
      end
      return y;
   endfunction

   task check_field(input string name, input logic [15:0] want, input logic [15:0] got);
      if (want !== got) begin
         error_count++;
         $display("%0t: %s mismatch, expected %h got %h", $time, name, want, got);
      end
   endtask

   initial begin
      error_count   = 0;
      pending_count = 0;
   end

   always @(posedge clock) begin
      alu_result_type want, got;
      if (reset) begin
         alu_result_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = alu_result_type'(rsp_tdata[19:0]);
            if (alu_result_q.size() == 0) begin
               error_count++;
               $display("%0t: result transfer with nothing expected, got %h", $time, rsp_tdata);
            end else begin
               want = alu_result_q.pop_front();
               check_field("result", want.result, got.result);
               check_field("zero_flag", {15'd0, want.zero}, {15'd0, got.zero});
               check_field("negative_flag", {15'd0, want.negative}, {15'd0, got.negative});
               check_field("half_flag", {15'd0, want.half}, {15'd0, got.half});
               check_field("carry_flag", {15'd0, want.carry}, {15'd0, got.carry});
            end
         end
         if (req_tvalid && req_tready)
            alu_result_q.push_back(compute_alu(req_tuser, req_tdata));
      end
      pending_count = alu_result_q.size();
   end

endmodule

### test/testbench.sv
// top of the cpu alu with flags test: clock, reset, directed and random requests,
// random stalls on both channels, watchdog and verdict
// depends on cawf_pkg, cpu_alu_with_flags and alu_flag_checker
module testbench;
   import cawf_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED_FIRST = 5'd21;
   localparam logic [OP_W-1:0] OP_UNUSED_LAST  = 5'd31;
   localparam int RANDOM_ITEMS = 1000;
   localparam int QUIET_ITEMS  = 100;
   localparam int IDLE_LIMIT   = 500;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;
   logic [4:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;
   int          error_count;
   int          pending_count;
   int          idle_cycles;
   logic        quiet;

   cpu_alu_with_flags u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   alu_flag_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // drive one request starting at a falling edge, return at the falling edge after its transfer
   task send_op(input logic [4:0] op, input logic [7:0] acc, input logic [15:0] reg_value,
                input logic [15:0] operand, input logic [2:0] bit_index,
                input logic carry_in, input logic zero_in);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 11)) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = op;
      req_tdata  = {3'b000, zero_in, carry_in, bit_index, operand, reg_value, acc};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hff;
         2: return 8'h0f;
         3: return 8'h80;
         default: return 8'($urandom);
      endcase
   endfunction

   // result side stalls in bursts
   initial begin
      rsp_tready = 1'b1;
      forever begin
         @(negedge clock);
         if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_tready = 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clock);
            rsp_tready = 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      logic [4:0] op;
      idle_cycles = 0;
      quiet      = 1'b0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // carries, borrows and zero results at the byte limits, then shifts, bit tests, 16-bit adds and unused codes
      send_op(OP_ADD,   8'hff, 16'h0000, 16'hff01, 3'd0, 1'b0, 1'b0);
      send_op(OP_ADC,   8'hff, 16'h0000, 16'h0000, 3'd0, 1'b1, 1'b0);
      send_op(OP_SUB,   8'h00, 16'h0000, 16'h0001, 3'd0, 1'b0, 1'b1);
      send_op(OP_SBC,   8'h10, 16'h0000, 16'h000f, 3'd0, 1'b1, 1'b0);
      send_op(OP_AND,   8'hf0, 16'h0000, 16'h0f0f, 3'd0, 1'b1, 1'b0);
      send_op(OP_XOR,   8'hff, 16'h0000, 16'h00ff, 3'd0, 1'b1, 1'b0);
      send_op(OP_OR,    8'h00, 16'hffff, 16'hff00, 3'd0, 1'b1, 1'b0);
      send_op(OP_CP,    8'h42, 16'h0000, 16'h0042, 3'd0, 1'b1, 1'b0);
      send_op(OP_CP,    8'h00, 16'h0000, 16'h00ff, 3'd0, 1'b0, 1'b0);
      send_op(OP_INC,   8'h00, 16'hffff, 16'h0000, 3'd0, 1'b1, 1'b0);
      send_op(OP_DEC,   8'h00, 16'hff00, 16'h0000, 3'd0, 1'b0, 1'b1);
      send_op(OP_RLC,   8'h00, 16'h0080, 16'h0000, 3'd0, 1'b0, 1'b0);
      send_op(OP_RRC,   8'h00, 16'h0001, 16'h0000, 3'd0, 1'b0, 1'b0);
      send_op(OP_RL,    8'h00, 16'h0080, 16'h0000, 3'd0, 1'b0, 1'b0);
      send_op(OP_RR,    8'h00, 16'h0000, 16'h0000, 3'd0, 1'b1, 1'b1);
      send_op(OP_SLA,   8'h00, 16'h0080, 16'h0000, 3'd0, 1'b0, 1'b0);
      send_op(OP_SRA,   8'h00, 16'h0081, 16'h0000, 3'd0, 1'b0, 1'b0);
      send_op(OP_SWAP,  8'h00, 16'h00f0, 16'h0000, 3'd0, 1'b1, 1'b1);
      send_op(OP_SRL,   8'h00, 16'h0001, 16'h0000, 3'd0, 1'b1, 1'b0);
      send_op(OP_BIT,   8'h00, 16'hff7f, 16'h0000, 3'd7, 1'b1, 1'b0);
      send_op(OP_BIT,   8'h00, 16'h0080, 16'h0000, 3'd7, 1'b0, 1'b1);
      send_op(OP_ADD16, 8'h00, 16'h0fff, 16'h0001, 3'd0, 1'b0, 1'b1);
      send_op(OP_ADD16, 8'h00, 16'hffff, 16'h0001, 3'd0, 1'b0, 1'b0);
      send_op(OP_ADDSP, 8'h00, 16'hffff, 16'hff80, 3'd0, 1'b1, 1'b1);
      send_op(OP_UNUSED_FIRST, 8'hff, 16'hffff, 16'hffff, 3'd7, 1'b1, 1'b1);
      send_op(OP_UNUSED_LAST,  8'hff, 16'hffff, 16'hffff, 3'd7, 1'b0, 1'b0);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i >= RANDOM_ITEMS - QUIET_ITEMS)
            quiet = 1'b1;
         if ($urandom_range(0, 9) == 0)
            op = 5'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
         else
            op = 5'($urandom_range(OP_ADD, OP_ADDSP));
         send_op(op, pick_byte(), {pick_byte(), pick_byte()}, {pick_byte(), pick_byte()},
                 3'($urandom), 1'($urandom), 1'($urandom));
      end
      req_tvalid = 1'b0;

      while (pending_count != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
